/* rtl/core/gregorian_date_add_days_macros.svh */
// ----------------------------------------------------------------------------
// gregorian date add days - assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset gated
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// same-cycle implication
`define GDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg
// types, constants and calendar helpers for the gregorian date adder
// ----------------------------------------------------------------------------
`default_nettype none

package gda_pkg;

  localparam logic [13:0] YearMax     = 14'd9999;
  localparam logic [13:0] YearCycle   = 14'd400;
  localparam logic [8:0]  CycleLast   = 9'd399;
  localparam logic [3:0]  MonthMax    = 4'd12;
  localparam logic [3:0]  MonthFeb    = 4'd2;
  localparam logic [8:0]  DaysYear    = 9'd365;
  localparam logic [8:0]  DaysLeap    = 9'd366;
  localparam logic [2:0]  RedSteps    = 3'd4;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [14:0] days_to_add;
  } gda_req_t;

  typedef struct packed {
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic        bad_date;
  } gda_rsp_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic check;
    logic strip;
    logic walk;
  } gda_cmd_t;

  typedef struct packed {
    logic red_last;
    logic bad;
    logic year_more;
    logic month_more;
  } gda_sts_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_YEARS  = 6'b001000,
    S_MONTHS = 6'b010000,
    S_DONE   = 6'b100000
  } gda_state_e;

  // leap test from the year modulo 400
  function automatic logic is_leap(input logic [8:0] r);
    return (r == 9'd0) ||
           ((r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
    logic [4:0] d;
    case (m) inside
      4'd2:                                  d = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:               d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      default:                               d = 5'd0;
    endcase
    return d;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gda_ctrl.sv */
// ----------------------------------------------------------------------------
// gda_ctrl
// sequencer: year reduction, validation, year strip and month walk
// ----------------------------------------------------------------------------
`default_nettype none

module gda_ctrl
  import gda_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire gda_sts_t sts_i,
  output gda_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  gda_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.red_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad ? S_DONE : S_YEARS;
      end
      S_YEARS: begin
        if (sts_i.year_more) cmd_o.strip = 1'b1;
        else state_d = S_MONTHS;
      end
      S_MONTHS: begin
        if (sts_i.month_more) cmd_o.walk = 1'b1;
        else state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

/* rtl/core/gda_dpath.sv */
// ----------------------------------------------------------------------------
// gda_dpath
// date registers, modulo-400 tracking and the day-count arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module gda_dpath
  import gda_pkg::*;
(
  input  wire logic     clk_i,
  input  wire gda_req_t req_i,
  input  wire gda_cmd_t cmd_i,
  output gda_sts_t      sts_o,
  output gda_rsp_t      rsp_o
);

  logic [13:0] year_q;
  logic [13:0] red_q;
  logic [2:0]  step_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [14:0] add_q;
  logic [15:0] total_q;
  logic        bad_q;

  logic [13:0] red_sub;
  logic        leap;
  logic [4:0]  mdays;
  logic [8:0]  ydays;
  logic [15:0] total_start;
  logic        bad_now;

  assign red_sub = YearCycle << step_q;
  assign leap    = is_leap(red_q[8:0]);
  assign mdays   = month_days(month_q, leap);
  assign ydays   = leap ? DaysLeap : DaysYear;

  // february adds one when the start month is past it in a leap year
  assign total_start = 16'(day_q) + 16'(days_before(month_q)) + 16'(add_q) +
                       16'(leap && (month_q > MonthFeb));

  assign bad_now = (year_q == 14'd0) || (year_q > YearMax) ||
                   (month_q == 4'd0) || (month_q > MonthMax) ||
                   (day_q == 5'd0) || (day_q > mdays);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q  <= req_i.start_year;
      red_q   <= req_i.start_year;
      month_q <= req_i.start_month;
      day_q   <= req_i.start_day;
      add_q   <= req_i.days_to_add;
      step_q  <= RedSteps;
    end
    if (cmd_i.reduce) begin
      // restoring reduction by 400 scaled down one power of two a cycle
      if (red_q >= red_sub) red_q <= red_q - red_sub;
      step_q <= step_q - 3'd1;
    end
    if (cmd_i.check) begin
      bad_q   <= bad_now;
      total_q <= total_start;
      month_q <= 4'd1;
    end
    if (cmd_i.strip) begin
      total_q <= total_q - 16'(ydays);
      year_q  <= year_q + 14'd1;
      red_q   <= (red_q[8:0] == CycleLast) ? 14'd0 : red_q + 14'd1;
    end
    if (cmd_i.walk) begin
      total_q <= total_q - 16'(mdays);
      month_q <= month_q + 4'd1;
    end
  end

  assign sts_o.red_last   = (step_q == 3'd0);
  assign sts_o.bad        = bad_now;
  assign sts_o.year_more  = (total_q > 16'(ydays));
  assign sts_o.month_more = (month_q < MonthMax) && (total_q > 16'(mdays));

  assign rsp_o.end_year  = bad_q ? 14'd0 : year_q;
  assign rsp_o.end_month = bad_q ? 4'd0 : month_q;
  assign rsp_o.end_day   = bad_q ? 5'd0 : total_q[4:0];
  assign rsp_o.bad_date  = bad_q;

endmodule

`default_nettype wire

/* rtl/core/gregorian_date_add_days.sv */
// one request at a time; an invalid date goes from validation straight to done
// the year strip loop (one year a cycle) and the month walk (one month a cycle)
// follow the reduction of the year modulo 400
// busy_o is high while the sequencer is out of idle, through the done cycle; the result is shown
// for one cycle with done_o and cannot be stalled
// reset (rst_ni low, asynchronous) returns the sequencer to idle
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// adds a day count to a gregorian date, flags invalid start dates
// ----------------------------------------------------------------------------
`default_nettype none

`include "gregorian_date_add_days_macros.svh"

module gregorian_date_add_days
  import gda_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire gda_req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output gda_rsp_t      rsp_o
);

  gda_cmd_t cmd;
  gda_sts_t sts;

  logic req_accept;
  logic rsp_zero;
  logic rsp_legal;

  gda_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  gda_dpath u_dpath (
    .clk_i (clk_i),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

  assign req_accept = start_i && !busy_o;
  assign rsp_zero   = (rsp_o.end_year == 14'd0) && (rsp_o.end_month == 4'd0) &&
                      (rsp_o.end_day == 5'd0);
  assign rsp_legal  = (rsp_o.end_month >= 4'd1) && (rsp_o.end_month <= MonthMax) &&
                      (rsp_o.end_day != 5'd0);

  `GDA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, req_accept, busy_o && !done_o, "not busy")
  `GDA_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o && !done_o, "not idle")
  `GDA_ASSERT_SAME(a_bad_zero, clk_i, rst_ni, done_o && rsp_o.bad_date, rsp_zero, "bad")
  `GDA_ASSERT_SAME(a_good_range, clk_i, rst_ni, done_o && !rsp_o.bad_date, rsp_legal, "range")

endmodule

`default_nettype wire
